// ===== hw/rtl/bpc_pkg.sv =====
// Shared widths, types and constants of the barometric compensation pipeline.
// No dependencies; every other file refers to it by scoped name.
`timescale 1ns / 1ps

package bpc_pkg;

  // field widths
  localparam int RAW_T_W   = 16;
  localparam int RAW_P_W   = 24;
  localparam int CAL_W     = 16;
  localparam int CFG_IDX_W = 2;
  localparam int PRESS_W   = 25;
  localparam int TEMP_W    = 15;

  // internal widths
  localparam int TT_W  = 31;   // square of the centered temperature code
  localparam int QT_W  = 48;   // coefficient times square
  localparam int SW    = 53;   // scaled sensor values s1..s3
  localparam int VW    = 56;   // dc, a, b and the scaled factors
  localparam int LIMB  = 32;
  localparam int NA    = 3;
  localparam int NB    = 2;
  localparam int MA_W  = NA * LIMB;
  localparam int MB_W  = NB * LIMB;
  localparam int MP_W  = MA_W + MB_W;
  localparam int DDW   = 128;  // signed denominator sum
  localparam int DW    = 112;  // denominator magnitude
  localparam int NW    = 127;  // numerator magnitude
  localparam int QB    = 40;   // quotient bits kept
  localparam int PCW   = 43;   // final pressure arithmetic
  localparam int TNW   = 33;   // temperature numerator

  typedef logic signed [CAL_W-1:0] cal_t;
  typedef logic [TT_W-1:0]         sq_t;
  typedef logic signed [QT_W-1:0]  qt_t;
  typedef logic signed [SW-1:0]    s_t;
  typedef logic signed [VW-1:0]    v_t;
  typedef logic [VW-1:0]           vmag_t;
  typedef logic [MA_W-1:0]         mula_t;
  typedef logic [MB_W-1:0]         mulb_t;
  typedef logic [MP_W-1:0]         mulp_t;
  typedef logic signed [DDW-1:0]   dd_t;
  typedef logic [DW-1:0]           den_t;
  typedef logic [NW-1:0]           num_t;
  typedef logic [QB-1:0]           quo_t;
  typedef logic signed [PCW-1:0]   pcalc_t;
  typedef logic signed [TNW-1:0]   tnum_t;
  typedef logic signed [TEMP_W-1:0] temp_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_QUAD_LOW   = 2'd0,
    REG_QUAD_MID   = 2'd1,
    REG_QUAD_HIGH  = 2'd2,
    REG_OFFSET_MID = 2'd3
  } cfg_reg_t;

  // flags and temperature that ride along with the divider
  typedef struct packed {
    logic  zf;    // zero denominator
    logic  ovf;   // quotient beyond the kept bits
    logic  neg;   // correction term is subtracted
    temp_t temp;
  } side_t;

  localparam s_t S1_BASE = 53'sd61572651155456;   // 7 * 2^43
  localparam s_t S3_BASE = 53'sd202310139510784;  // 23 * 2^43
  localparam int OFS_SHIFT  = 35;
  localparam int RAW_SHIFT  = 24;

  localparam int PRESS_BASE_Q8 = 11520000;
  localparam int PRESS_SPAN_Q8 = 107520000;
  localparam int PRESS_MAX_Q8  = 33554431;

  localparam tnum_t TEMP_GAIN  = 33'sd17500;
  localparam tnum_t TEMP_OFS   = 33'sd294912000;
  localparam tnum_t TEMP_ROUND = 33'sd65535;
  localparam int    TEMP_SHIFT = 16;
  localparam temp_t TEMP_MIN   = -15'sd4500;
  localparam temp_t TEMP_MAX   = 15'sd12999;

  function automatic vmag_t mag_v(input v_t x);
    return x[VW-1] ? vmag_t'(-x) : vmag_t'(x);
  endfunction

endpackage

// ===== hw/rtl/barometric_pressure_compensation.sv =====
// Top level of the barometric compensation pipeline: raw codes in, Pa*256 and 0.01 C out.
// Depends on bpc_pkg, bpc_mul (limb multiplier) and bpc_div (bit-per-stage divider).
`timescale 1ns / 1ps

// Channel   Ports                                           Handshake
// --------  ----------------------------------------------  -----------------------------
// request   in_raw_temp, in_raw_pressure                    start high while busy low
// result    out_pressure_q8, out_temp_centi, out_fault      out_valid, one cycle, no stall
// config    cfg_index, cfg_data                             cfg_we, taken at once
//
// One request may enter every cycle; busy stays low.
// Each result follows its request through stages p1..p11, the 40-stage
// divider and the output stages f1 and f2.
// Reset (rst_n low, synchronous) drops all requests in flight and clears the
// calibration words to zero.
// The result side has no back-pressure, so nothing in the pipeline ever holds.

module barometric_pressure_compensation (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [bpc_pkg::RAW_T_W-1:0]       in_raw_temp,
  input  logic [bpc_pkg::RAW_P_W-1:0]       in_raw_pressure,
  output logic                              out_valid,
  output logic [bpc_pkg::PRESS_W-1:0]       out_pressure_q8,
  output bpc_pkg::temp_t                    out_temp_centi,
  output logic                              out_fault,
  input  logic                              cfg_we,
  input  logic [bpc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  bpc_pkg::cal_t                     cfg_data
);

  // ---------------------------------------------------------------- config
  bpc_pkg::cal_t cal_quad_low_r, cal_quad_mid_r, cal_quad_high_r, cal_offset_mid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_quad_low_r   <= '0;
      cal_quad_mid_r   <= '0;
      cal_quad_high_r  <= '0;
      cal_offset_mid_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        bpc_pkg::REG_QUAD_LOW:   cal_quad_low_r   <= cfg_data;
        bpc_pkg::REG_QUAD_MID:   cal_quad_mid_r   <= cfg_data;
        bpc_pkg::REG_QUAD_HIGH:  cal_quad_high_r  <= cfg_data;
        bpc_pkg::REG_OFFSET_MID: cal_offset_mid_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  // ---------------------------------------------------------------- valid chain
  // Stage valids p1..p11 travel beside the data; reset clears them.
  logic [11:1] v_r;
  logic [11:1] v_nxt;

  always_comb begin
    v_nxt[1] = start & ~busy;
    for (int k = 2; k <= 11; k++) begin
      v_nxt[k] = v_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  // ---------------------------------------------------------------- p1: capture
  logic [bpc_pkg::RAW_T_W-1:0] rt1_r;
  logic [bpc_pkg::RAW_P_W-1:0] rp1_r, rp2_r, rp3_r, rp4_r, rp5_r;

  always_ff @(posedge clk) begin
    rt1_r <= in_raw_temp;
    rp1_r <= in_raw_pressure;
  end

  // ---------------------------------------------------------------- p2: square, temperature
  logic signed [bpc_pkg::RAW_T_W-1:0] tc;
  logic signed [31:0]                 sq32;
  bpc_pkg::tnum_t                     tnum, tadj;
  bpc_pkg::sq_t                       tt2_nxt, tt2_r;
  bpc_pkg::temp_t                     temp2_nxt, temp2_r, temp3_r, temp4_r, temp5_r, temp6_r;
  bpc_pkg::temp_t                     temp7_r, temp8_r, temp9_r, temp10_r, temp11_r;

  always_comb begin
    // center the code: raw - 32768 is the code with its top bit flipped
    tc        = {~rt1_r[bpc_pkg::RAW_T_W-1], rt1_r[bpc_pkg::RAW_T_W-2:0]};
    sq32      = tc * tc;
    tt2_nxt   = sq32[bpc_pkg::TT_W-1:0];
    // 175/65536 scaled by 100, truncated toward zero
    tnum      = bpc_pkg::tnum_t'(rt1_r) * bpc_pkg::TEMP_GAIN - bpc_pkg::TEMP_OFS;
    tadj      = tnum + (tnum[bpc_pkg::TNW-1] ? bpc_pkg::TEMP_ROUND : bpc_pkg::tnum_t'(0));
    temp2_nxt = bpc_pkg::temp_t'(tadj >>> bpc_pkg::TEMP_SHIFT);
  end

  always_ff @(posedge clk) begin
    tt2_r   <= tt2_nxt;
    temp2_r <= temp2_nxt;
    rp2_r   <= rp1_r;
  end

  // ---------------------------------------------------------------- p3: quadratic terms
  bpc_pkg::qt_t ql3_r, qm3_r, qh3_r;

  always_ff @(posedge clk) begin
    ql3_r   <= bpc_pkg::qt_t'(cal_quad_low_r)  * bpc_pkg::qt_t'(tt2_r);
    qm3_r   <= bpc_pkg::qt_t'(cal_quad_mid_r)  * bpc_pkg::qt_t'(tt2_r);
    qh3_r   <= bpc_pkg::qt_t'(cal_quad_high_r) * bpc_pkg::qt_t'(tt2_r);
    temp3_r <= temp2_r;
    rp3_r   <= rp2_r;
  end

  // ---------------------------------------------------------------- p4: sensor values
  bpc_pkg::s_t s1_4_r, s2_4_r, s3_4_r;

  always_ff @(posedge clk) begin
    s1_4_r  <= bpc_pkg::S1_BASE + bpc_pkg::s_t'(ql3_r);
    s2_4_r  <= (bpc_pkg::s_t'(cal_offset_mid_r) <<< bpc_pkg::OFS_SHIFT)
             + bpc_pkg::s_t'(qm3_r);
    s3_4_r  <= bpc_pkg::S3_BASE + bpc_pkg::s_t'(qh3_r);
    temp4_r <= temp3_r;
    rp4_r   <= rp3_r;
  end

  // ---------------------------------------------------------------- p5: linear combinations
  logic [bpc_pkg::RAW_P_W+bpc_pkg::RAW_SHIFT-1:0] r4;
  bpc_pkg::v_t dc5_r, a5_r, b5_r, m1_5_r, m2_5_r, m3_5_r;
  bpc_pkg::s_t s2_5_r, s3_5_r;
  logic        eq5_r;

  assign r4 = {rp4_r, {bpc_pkg::RAW_SHIFT{1'b0}}};

  always_ff @(posedge clk) begin
    dc5_r   <= bpc_pkg::v_t'(s2_4_r) * 12 - bpc_pkg::v_t'(s3_4_r) * 7
             - bpc_pkg::v_t'(s1_4_r) * 5;
    a5_r    <= bpc_pkg::v_t'(s2_4_r) - bpc_pkg::v_t'(s3_4_r);
    b5_r    <= bpc_pkg::v_t'(s1_4_r) - bpc_pkg::v_t'(r4);
    m1_5_r  <= bpc_pkg::v_t'(s1_4_r) * -7;
    m2_5_r  <= bpc_pkg::v_t'(s2_4_r) * -5;
    m3_5_r  <= bpc_pkg::v_t'(s1_4_r) * 12;
    s2_5_r  <= s2_4_r;
    s3_5_r  <= s3_4_r;
    eq5_r   <= s1_4_r == s2_4_r;
    temp5_r <= temp4_r;
    rp5_r   <= rp4_r;
  end

  // ---------------------------------------------------------------- p6: magnitudes and signs
  bpc_pkg::vmag_t ma6_r [0:4];
  bpc_pkg::vmag_t mb6_r [0:3];
  logic [3:0]     sg6_r, sg7_r, sg8_r;
  logic           sa6_r, sb6_r, fz6_r;
  bpc_pkg::vmag_t absb6_r, absb7_r, absb8_r;

  always_ff @(posedge clk) begin
    ma6_r[0] <= bpc_pkg::mag_v(m1_5_r);
    mb6_r[0] <= bpc_pkg::mag_v(bpc_pkg::v_t'(s2_5_r));
    ma6_r[1] <= bpc_pkg::mag_v(m2_5_r);
    mb6_r[1] <= bpc_pkg::mag_v(bpc_pkg::v_t'(s3_5_r));
    ma6_r[2] <= bpc_pkg::mag_v(m3_5_r);
    mb6_r[2] <= bpc_pkg::mag_v(bpc_pkg::v_t'(s3_5_r));
    ma6_r[3] <= bpc_pkg::mag_v(dc5_r);
    mb6_r[3] <= bpc_pkg::vmag_t'({rp5_r, {bpc_pkg::RAW_SHIFT{1'b0}}});
    ma6_r[4] <= bpc_pkg::mag_v(a5_r);
    sg6_r[0] <= m1_5_r[bpc_pkg::VW-1] ^ s2_5_r[bpc_pkg::SW-1];
    sg6_r[1] <= m2_5_r[bpc_pkg::VW-1] ^ s3_5_r[bpc_pkg::SW-1];
    sg6_r[2] <= m3_5_r[bpc_pkg::VW-1] ^ s3_5_r[bpc_pkg::SW-1];
    sg6_r[3] <= dc5_r[bpc_pkg::VW-1];
    sa6_r    <= a5_r[bpc_pkg::VW-1];
    sb6_r    <= b5_r[bpc_pkg::VW-1];
    absb6_r  <= bpc_pkg::mag_v(b5_r);
    fz6_r    <= eq5_r | (dc5_r == '0);
    temp6_r  <= temp5_r;
  end

  // ---------------------------------------------------------------- p7..p8: products
  // Four denominator products and |a| times the pressure span.
  bpc_pkg::mulp_t prod [0:4];
  bpc_pkg::mulp_t nsp;

  for (genvar k = 0; k < 4; k++) begin : g_ddmul
    bpc_mul u_mul (
      .clk (clk),
      .a   (bpc_pkg::mula_t'(ma6_r[k])),
      .b   (bpc_pkg::mulb_t'(mb6_r[k])),
      .p   (prod[k])
    );
  end

  bpc_mul u_mul_span (
    .clk (clk),
    .a   (bpc_pkg::mula_t'(ma6_r[4])),
    .b   (bpc_pkg::mulb_t'(bpc_pkg::PRESS_SPAN_Q8)),
    .p   (prod[4])
  );

  logic sa7_r, sb7_r, fz7_r, sa8_r, sb8_r, fz8_r;

  always_ff @(posedge clk) begin
    sg7_r   <= sg6_r;
    sa7_r   <= sa6_r;
    sb7_r   <= sb6_r;
    fz7_r   <= fz6_r;
    absb7_r <= absb6_r;
    temp7_r <= temp6_r;
    sg8_r   <= sg7_r;
    sa8_r   <= sa7_r;
    sb8_r   <= sb7_r;
    fz8_r   <= fz7_r;
    absb8_r <= absb7_r;
    temp8_r <= temp7_r;
  end

  // ---------------------------------------------------------------- p9..p10: numerator, Dd
  // Multiply |a|*span by |b| while the signed denominator terms are summed.
  bpc_mul u_mul_num (
    .clk (clk),
    .a   (prod[4][bpc_pkg::MA_W-1:0]),
    .b   (bpc_pkg::mulb_t'(absb8_r)),
    .p   (nsp)
  );

  bpc_pkg::dd_t t9_r [0:3];
  bpc_pkg::dd_t dd10_r;
  logic         sa9_r, sb9_r, fz9_r, sa10_r, sb10_r, fz10_r;

  always_ff @(posedge clk) begin
    for (int k = 0; k < 4; k++) begin
      t9_r[k] <= sg8_r[k] ? -bpc_pkg::dd_t'(prod[k][bpc_pkg::DDW-1:0])
                          :  bpc_pkg::dd_t'(prod[k][bpc_pkg::DDW-1:0]);
    end
    sa9_r    <= sa8_r;
    sb9_r    <= sb8_r;
    fz9_r    <= fz8_r;
    temp9_r  <= temp8_r;
    dd10_r   <= t9_r[0] + t9_r[1] + t9_r[2] + t9_r[3];
    sa10_r   <= sa9_r;
    sb10_r   <= sb9_r;
    fz10_r   <= fz9_r;
    temp10_r <= temp9_r;
  end

  // ---------------------------------------------------------------- p11: magnitudes
  bpc_pkg::dd_t  ddabs;
  bpc_pkg::den_t den11_r;
  bpc_pkg::num_t num11_r;
  logic          dneg11_r, ddz11_r, sa11_r, sb11_r, fz11_r;

  assign ddabs = dd10_r[bpc_pkg::DDW-1] ? -dd10_r : dd10_r;

  always_ff @(posedge clk) begin
    den11_r  <= ddabs[bpc_pkg::DW-1:0];
    num11_r  <= nsp[bpc_pkg::NW-1:0];
    dneg11_r <= dd10_r[bpc_pkg::DDW-1];
    ddz11_r  <= dd10_r == '0;
    sa11_r   <= sa10_r;
    sb11_r   <= sb10_r;
    fz11_r   <= fz10_r;
    temp11_r <= temp10_r;
  end

  // ---------------------------------------------------------------- divider
  // Quotient overflows the kept bits exactly when the high numerator part
  // already reaches the denominator.
  bpc_pkg::side_t dside_i, dside_o;
  logic           dv_o;
  bpc_pkg::quo_t  dquo_o;
  bpc_pkg::den_t  drem_o, dden_o;

  always_comb begin
    dside_i.zf   = fz11_r | ddz11_r;
    dside_i.ovf  = bpc_pkg::den_t'(num11_r[bpc_pkg::NW-1:bpc_pkg::QB]) >= den11_r;
    dside_i.neg  = (sa11_r == sb11_r) != dneg11_r;
    dside_i.temp = temp11_r;
  end

  bpc_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v_r[11]),
    .in_num    (num11_r),
    .in_den    (den11_r),
    .in_side   (dside_i),
    .out_valid (dv_o),
    .out_quo   (dquo_o),
    .out_rem   (drem_o),
    .out_den   (dden_o),
    .out_side  (dside_o)
  );

  // ---------------------------------------------------------------- f1: rounding flags
  logic             fv_r, fv_nxt;
  logic             half_r, gt_r, rmz_r;
  bpc_pkg::quo_t    fq_r;
  bpc_pkg::side_t   fside_r;
  logic [bpc_pkg::DW:0] rm2, den2;

  assign rm2    = {drem_o, 1'b0};
  assign den2   = {1'b0, dden_o};
  assign fv_nxt = dv_o;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r <= 1'b0;
    end else begin
      fv_r <= fv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    half_r  <= rm2 >= den2;
    gt_r    <= rm2 > den2;
    rmz_r   <= drem_o == '0;
    fq_r    <= dquo_o;
    fside_r <= dside_o;
  end

  // ---------------------------------------------------------------- f2: pressure, saturate
  bpc_pkg::pcalc_t qs, pbase, pval, fl;
  logic [bpc_pkg::PRESS_W-1:0] press_nxt;
  logic                        fault_nxt;
  logic                        out_valid_r;
  logic [bpc_pkg::PRESS_W-1:0] out_pressure_q8_r;
  bpc_pkg::temp_t              out_temp_centi_r;
  logic                        out_fault_r;

  always_comb begin
    qs        = bpc_pkg::pcalc_t'(fq_r);
    pbase     = bpc_pkg::pcalc_t'(bpc_pkg::PRESS_BASE_Q8);
    fl        = pbase - qs - bpc_pkg::pcalc_t'(1);
    pval      = '0;
    press_nxt = '0;
    fault_nxt = 1'b0;
    if (!fside_r.neg) begin
      // add the correction, round half up
      pval = pbase + qs + bpc_pkg::pcalc_t'(half_r);
    end else if (rmz_r) begin
      pval = pbase - qs;
    end else if (fl >= 0) begin
      pval = fl + bpc_pkg::pcalc_t'(!gt_r);
    end else if (fq_r == bpc_pkg::quo_t'(bpc_pkg::PRESS_BASE_Q8) && !half_r) begin
      pval = '0;
    end else begin
      pval = -bpc_pkg::pcalc_t'(1);
    end

    if (fside_r.zf) begin
      fault_nxt = 1'b1;
    end else if (fside_r.ovf) begin
      // drive to the rail on the side of the correction sign
      fault_nxt = 1'b1;
      press_nxt = fside_r.neg ? '0 : bpc_pkg::PRESS_W'(bpc_pkg::PRESS_MAX_Q8);
    end else if (pval < 0) begin
      fault_nxt = 1'b1;
    end else if (pval > bpc_pkg::pcalc_t'(bpc_pkg::PRESS_MAX_Q8)) begin
      fault_nxt = 1'b1;
      press_nxt = bpc_pkg::PRESS_W'(bpc_pkg::PRESS_MAX_Q8);
    end else begin
      press_nxt = pval[bpc_pkg::PRESS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= fv_r;
    end
  end

  always_ff @(posedge clk) begin
    out_pressure_q8_r <= press_nxt;
    out_temp_centi_r  <= fside_r.temp;
    out_fault_r       <= fault_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_pressure_q8 = out_pressure_q8_r;
  assign out_temp_centi  = out_temp_centi_r;
  assign out_fault       = out_fault_r;

  // ---------------------------------------------------------------- checks
  a_cfg_offset: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_we && cfg_index == bpc_pkg::REG_OFFSET_MID) |=> cal_offset_mid_r == $past(cfg_data))
    else $error("offset register write lost");

  a_ovf_fault: assert property (@(posedge clk) disable iff (!rst_n)
    (dv_o && dside_o.ovf) |-> ##2 (out_valid && out_fault))
    else $error("quotient overflow did not raise fault");

  a_zero_den: assert property (@(posedge clk) disable iff (!rst_n)
    (dv_o && dside_o.zf) |-> ##2 (out_valid && out_fault && out_pressure_q8 == '0))
    else $error("zero denominator did not give faulted zero pressure");

  a_temp_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_temp_centi >= bpc_pkg::TEMP_MIN && out_temp_centi <= bpc_pkg::TEMP_MAX))
    else $error("temperature out of range");

endmodule

// ===== hw/rtl/bpc_mul.sv =====
// Two-stage unsigned multiplier: 32x32 limb products, then one registered sum.
// Depends on bpc_pkg for limb counts and widths.
`timescale 1ns / 1ps

module bpc_mul (
  input  logic           clk,
  input  bpc_pkg::mula_t a,
  input  bpc_pkg::mulb_t b,
  output bpc_pkg::mulp_t p
);

  logic [2*bpc_pkg::LIMB-1:0] pp_nxt [0:bpc_pkg::NA*bpc_pkg::NB-1];
  logic [2*bpc_pkg::LIMB-1:0] pp_r   [0:bpc_pkg::NA*bpc_pkg::NB-1];
  bpc_pkg::mulp_t p_nxt, p_r;

  // limb products
  always_comb begin
    for (int i = 0; i < bpc_pkg::NA; i++) begin
      for (int j = 0; j < bpc_pkg::NB; j++) begin
        pp_nxt[i*bpc_pkg::NB+j] = a[i*bpc_pkg::LIMB +: bpc_pkg::LIMB]
                                * b[j*bpc_pkg::LIMB +: bpc_pkg::LIMB];
      end
    end
  end

  // align and add
  always_comb begin
    p_nxt = '0;
    for (int i = 0; i < bpc_pkg::NA; i++) begin
      for (int j = 0; j < bpc_pkg::NB; j++) begin
        p_nxt = p_nxt + (bpc_pkg::mulp_t'(pp_r[i*bpc_pkg::NB+j]) << (bpc_pkg::LIMB*(i+j)));
      end
    end
  end

  always_ff @(posedge clk) begin
    pp_r <= pp_nxt;
    p_r  <= p_nxt;
  end

  assign p = p_r;

endmodule

// ===== hw/rtl/bpc_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, sideband carried along.
// Depends on bpc_pkg for widths and the sideband struct.
`timescale 1ns / 1ps

module bpc_div (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  bpc_pkg::num_t   in_num,
  input  bpc_pkg::den_t   in_den,
  input  bpc_pkg::side_t  in_side,
  output logic            out_valid,
  output bpc_pkg::quo_t   out_quo,
  output bpc_pkg::den_t   out_rem,
  output bpc_pkg::den_t   out_den,
  output bpc_pkg::side_t  out_side
);

  localparam int QB = bpc_pkg::QB;
  localparam int DW = bpc_pkg::DW;

  logic [QB:0]     v_r;
  logic [QB:0]     v_nxt;
  bpc_pkg::den_t   rem_r  [0:QB];
  bpc_pkg::den_t   rem_nxt[0:QB];
  bpc_pkg::den_t   den_r  [0:QB];
  bpc_pkg::quo_t   nlow_r [0:QB];
  bpc_pkg::quo_t   nlow_nxt[0:QB];
  bpc_pkg::quo_t   q_r    [0:QB];
  bpc_pkg::quo_t   q_nxt  [0:QB];
  bpc_pkg::side_t  side_r [0:QB];
  logic [DW:0]     trial  [0:QB-1];
  logic            ge     [0:QB-1];

  // entry: high numerator bits form the first partial remainder
  always_comb begin
    v_nxt[0]    = in_valid;
    rem_nxt[0]  = bpc_pkg::den_t'(in_num[bpc_pkg::NW-1:QB]);
    nlow_nxt[0] = in_num[QB-1:0];
    q_nxt[0]    = '0;
  end

  for (genvar k = 0; k < QB; k++) begin : g_step
    always_comb begin
      trial[k]      = {rem_r[k], nlow_r[k][QB-1]};
      ge[k]         = trial[k] >= {1'b0, den_r[k]};
      rem_nxt[k+1]  = ge[k] ? DW'(trial[k] - {1'b0, den_r[k]}) : DW'(trial[k]);
      nlow_nxt[k+1] = nlow_r[k] << 1;
      q_nxt[k+1]    = {q_r[k][QB-2:0], ge[k]};
      v_nxt[k+1]    = v_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r[0]  <= rem_nxt[0];
    nlow_r[0] <= nlow_nxt[0];
    q_r[0]    <= q_nxt[0];
    den_r[0]  <= in_den;
    side_r[0] <= in_side;
    for (int k = 1; k <= QB; k++) begin
      rem_r[k]  <= rem_nxt[k];
      nlow_r[k] <= nlow_nxt[k];
      q_r[k]    <= q_nxt[k];
      den_r[k]  <= den_r[k-1];
      side_r[k] <= side_r[k-1];
    end
  end

  assign out_valid = v_r[QB];
  assign out_quo   = q_r[QB];
  assign out_rem   = rem_r[QB];
  assign out_den   = den_r[QB];
  assign out_side  = side_r[QB];

endmodule
